/* src/smj_pkg.sv */
`timescale 1ns / 1ps

package smj_pkg;

  // table geometry
  localparam int unsigned RIGHT_GROUPS = 1024;
  localparam int unsigned IDX_W        = $clog2(RIGHT_GROUPS);
  localparam int unsigned CNT_W        = $clog2(RIGHT_GROUPS + 1);

  localparam int unsigned KEY_W = 32;
  localparam int unsigned ROW_W = 31;

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PROBE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // status codes
  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_MATCH   = 3'd2;
  localparam logic [2:0] ST_NOMATCH = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [KEY_W-1:0] key;
    logic [ROW_W-1:0]        first_row;
    logic [ROW_W-1:0]        group_len;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ROW_W-1:0] left_first_row;
    logic [ROW_W-1:0] left_count;
    logic [ROW_W-1:0] right_first_row;
    logic [ROW_W-1:0] right_count;
  } out_t;

  // one right group as stored in the table
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ROW_W-1:0]        start;
    logic [ROW_W-1:0]        length;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } ram_req_t;

endpackage

/* src/smj_ram.sv */
`timescale 1ns / 1ps

module smj_ram (
  input  logic              clk_i,
  input  smj_pkg::ram_req_t req_i,
  output smj_pkg::entry_t   rd_data_o
);

  smj_pkg::entry_t mem [smj_pkg::RIGHT_GROUPS];
  smj_pkg::entry_t rd_data_q;

  // single port, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/smj_ctrl.sv */
`timescale 1ns / 1ps

module smj_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  smj_pkg::in_t      in_data_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output smj_pkg::out_t     res_o,
  output smj_pkg::ram_req_t ram_req_o,
  input  smj_pkg::entry_t   rd_data_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                            state_q, state_d;
  logic [smj_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [smj_pkg::CNT_W-1:0]       ptr_q, ptr_d;
  logic [smj_pkg::CNT_W-1:0]       ptr_nxt;
  logic signed [smj_pkg::KEY_W-1:0] pkey_q, pkey_d;
  logic [smj_pkg::ROW_W-1:0]       pfirst_q, pfirst_d;
  logic [smj_pkg::ROW_W-1:0]       plen_q, plen_d;
  logic                            accept;

  assign in_stall_o = (state_q != S_IDLE) || !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign ptr_nxt    = ptr_q + smj_pkg::CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pkey_d      = pkey_q;
    pfirst_d    = pfirst_q;
    plen_d      = plen_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    ram_req_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.action)
            smj_pkg::ACT_LOAD: begin
              res_valid_o = 1'b1;
              if (cnt_q < smj_pkg::CNT_W'(smj_pkg::RIGHT_GROUPS)) begin
                ram_req_o.we           = 1'b1;
                ram_req_o.addr         = cnt_q[smj_pkg::IDX_W-1:0];
                ram_req_o.wdata.key    = in_data_i.key;
                ram_req_o.wdata.start  = in_data_i.first_row;
                ram_req_o.wdata.length = in_data_i.group_len;
                cnt_d                  = cnt_q + smj_pkg::CNT_W'(1);
                res_o.status           = smj_pkg::ST_LOADED;
              end else begin
                res_o.status = smj_pkg::ST_FULL;
              end
            end
            smj_pkg::ACT_PROBE: begin
              pkey_d   = in_data_i.key;
              pfirst_d = in_data_i.first_row;
              plen_d   = in_data_i.group_len;
              if (ptr_q < cnt_q) begin
                ram_req_o.re   = 1'b1;
                ram_req_o.addr = ptr_q[smj_pkg::IDX_W-1:0];
                state_d        = S_SCAN;
              end else begin
                res_valid_o          = 1'b1;
                res_o.status         = smj_pkg::ST_NOMATCH;
                res_o.left_first_row = in_data_i.first_row;
                res_o.left_count     = in_data_i.group_len;
              end
            end
            smj_pkg::ACT_CLEAR: begin
              cnt_d        = '0;
              ptr_d        = '0;
              res_valid_o  = 1'b1;
              res_o.status = smj_pkg::ST_CLEARED;
            end
            default: begin
              res_valid_o  = 1'b1;
              res_o.status = smj_pkg::ST_NOMATCH;
            end
          endcase
        end
      end
      S_SCAN: begin
        res_o.left_first_row = pfirst_q;
        res_o.left_count     = plen_q;
        if (rd_data_i.key < pkey_q) begin
          // step past a smaller right group
          ptr_d = ptr_nxt;
          if (ptr_nxt < cnt_q) begin
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = ptr_nxt[smj_pkg::IDX_W-1:0];
          end else begin
            res_valid_o  = 1'b1;
            res_o.status = smj_pkg::ST_NOMATCH;
            state_d      = S_IDLE;
          end
        end else if (rd_data_i.key == pkey_q) begin
          res_valid_o           = 1'b1;
          res_o.status          = smj_pkg::ST_MATCH;
          res_o.right_first_row = rd_data_i.start;
          res_o.right_count     = rd_data_i.length;
          state_d               = S_IDLE;
        end else begin
          res_valid_o  = 1'b1;
          res_o.status = smj_pkg::ST_NOMATCH;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkey_q   <= pkey_d;
    pfirst_q <= pfirst_d;
    plen_q   <= plen_d;
  end

endmodule

/* src/sort_merge_join_groups_core.sv */
`timescale 1ns / 1ps
// load, clear and unused actions: result appears on the output in the cycle after the transaction is accepted
// probe: the scan steps past loaded groups with smaller keys and registers the result when it
// stops on a loaded group, runs past the last one, or finds the pointer already there (no read)
// one table read per cycle through the single port; total steps are bounded by the loaded groups
// one item in flight; the next transaction is taken once the result register is free or draining
// reset: group count and scan pointer zero, table contents undefined, no clearing pass

module sort_merge_join_groups_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  smj_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output smj_pkg::out_t out_data_o
);

  smj_pkg::ram_req_t ram_req;
  smj_pkg::entry_t   rd_data;
  smj_pkg::out_t     res;
  logic              res_valid;
  logic              out_free;

  // result register state
  logic          out_valid_q, out_valid_d;
  smj_pkg::out_t out_data_q, out_data_d;

  // the result slot frees up when empty or when its transaction completes this edge
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer: group count, scan pointer, probe hold registers
  smj_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .rd_data_i   (rd_data)
  );

  // group table: key, first row and row count per entry
  smj_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // results are only produced while the slot is free, so no overwrite is possible
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/sort_merge_join_groups_core_tb.sv */
`timescale 1ns / 1ps

module sort_merge_join_groups_core_tb;
  import smj_pkg::*;

  // action code the block does not define, answered as no match
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int ITEMS_PER_PHASE = 80;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  sort_merge_join_groups_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // items waiting to be offered, and answers predicted for accepted items
  in_t  join_items_q[$];
  out_t join_answers_q[$];

  // scratch list of keys that get sorted before they become items
  int key_buf[$];

  // idling controls, written at the falling edge only
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic rx_hold      = 1'b0;

  int fail_count = 0;

  // predictor copy of the right-group table
  logic signed [KEY_W-1:0] tbl_key   [0:RIGHT_GROUPS-1];
  logic [ROW_W-1:0]        tbl_start [0:RIGHT_GROUPS-1];
  logic [ROW_W-1:0]        tbl_len   [0:RIGHT_GROUPS-1];
  int grp_count = 0;
  int scan_ptr  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sort_merge_join_groups_core_tb NOT OK");
    $finish;
  end

  // expected answer of one accepted transaction, updates the table copy
  function automatic out_t join_predict(in_t it);
    out_t r;
    r = '0;
    r.status = ST_NOMATCH;
    case (it.action)
      ACT_LOAD: begin
        if (grp_count < RIGHT_GROUPS) begin
          tbl_key[grp_count]   = it.key;
          tbl_start[grp_count] = it.first_row;
          tbl_len[grp_count]   = it.group_len;
          grp_count++;
          r.status = ST_LOADED;
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_PROBE: begin
        r.left_first_row = it.first_row;
        r.left_count     = it.group_len;
        // pointer never moves back
        while (scan_ptr < grp_count && $signed(tbl_key[scan_ptr]) < $signed(it.key))
          scan_ptr++;
        if (scan_ptr < grp_count && $signed(tbl_key[scan_ptr]) == $signed(it.key)) begin
          r.status          = ST_MATCH;
          r.right_first_row = tbl_start[scan_ptr];
          r.right_count     = tbl_len[scan_ptr];
        end
      end
      ACT_CLEAR: begin
        grp_count = 0;
        scan_ptr  = 0;
        r.status  = ST_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_item(logic [1:0] act, logic signed [KEY_W-1:0] key,
                                    logic [ROW_W-1:0] fr, logic [ROW_W-1:0] len);
    in_t it;
    it.action    = act;
    it.key       = key;
    it.first_row = fr;
    it.group_len = len;
    join_items_q.push_back(it);
  endfunction

  // row values: zero, all ones, small and full-width random
  function automatic logic [ROW_W-1:0] rand_row();
    int unsigned      r;
    logic [ROW_W-1:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) v = '0;
    else if (r == 1) v = '1;
    else if (r < 6) v = ROW_W'($urandom_range(1, 1000));
    else v = ROW_W'($urandom);
    return v;
  endfunction

  function automatic void sort_key_buf();
    int v;
    int j;
    for (int i = 1; i < key_buf.size(); i++) begin
      v = key_buf[i];
      j = i - 1;
      while (j >= 0 && key_buf[j] > v) begin
        key_buf[j + 1] = key_buf[j];
        j--;
      end
      key_buf[j + 1] = v;
    end
  endfunction

  // one join round: optional clear, sorted loads, sorted probes mostly on loaded keys
  function automatic int add_join_round();
    int   n;
    int   m;
    int   cnt;
    int   base;
    int   r;
    int   k;
    bit   narrow;
    int   loaded[$];
    cnt = 0;
    if ($urandom_range(0, 1) == 1) begin
      push_item(ACT_CLEAR, $urandom, rand_row(), rand_row());
      cnt++;
    end
    narrow = ($urandom_range(0, 3) != 0);
    base   = $urandom;
    n      = $urandom_range(1, 10);
    m      = $urandom_range(1, 10);
    key_buf.delete();
    for (int i = 0; i < n; i++) begin
      if (narrow) k = base + $urandom_range(0, 40);
      else k = $urandom;
      key_buf.push_back(k);
    end
    sort_key_buf();
    loaded = key_buf;
    foreach (loaded[i]) push_item(ACT_LOAD, loaded[i], rand_row(), rand_row());
    key_buf.delete();
    for (int i = 0; i < m; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) k = loaded[$urandom_range(0, loaded.size() - 1)];
      else if (r < 8) k = loaded[$urandom_range(0, loaded.size() - 1)] + 1;
      else if (narrow) k = base + $urandom_range(0, 40);
      else k = $urandom;
      key_buf.push_back(k);
    end
    sort_key_buf();
    foreach (key_buf[i]) push_item(ACT_PROBE, key_buf[i], rand_row(), rand_row());
    return cnt + n + m;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // wait until every item has been taken and answered
  task automatic wait_drain();
    @(negedge clk_i);
    while (join_items_q.size() != 0 || in_valid_i || join_answers_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int idle, input int stall);
    int cnt;
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    cnt = 0;
    while (cnt < ITEMS_PER_PHASE) begin
      if ($urandom_range(0, 99) < 15) begin
        push_item(2'($urandom_range(0, 3)), $urandom, rand_row(), rand_row());
        cnt++;
      end else begin
        cnt += add_join_round();
      end
    end
    wait_drain();
  endtask

  // sender: holds a stalled transaction, otherwise offers the next item or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) join_answers_q.push_back(join_predict(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (join_items_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= join_items_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random, or forced during a long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin
    forever begin
      wait (hold_req);
      @(negedge clk_i);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      rx_hold  = 1'b0;
      hold_req = 1'b0;
    end
  end

  // result checker against the oldest predicted answer
  always @(posedge clk_i) begin
    out_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (join_answers_q.size() == 0) begin
        note_failure($sformatf("unexpected result st=%0d lf=%0d lc=%0d rf=%0d rc=%0d",
                               out_data_o.status, out_data_o.left_first_row,
                               out_data_o.left_count, out_data_o.right_first_row,
                               out_data_o.right_count));
      end else begin
        exp = join_answers_q.pop_front();
        if (out_data_o.status !== exp.status ||
            out_data_o.left_first_row !== exp.left_first_row ||
            out_data_o.left_count !== exp.left_count ||
            out_data_o.right_first_row !== exp.right_first_row ||
            out_data_o.right_count !== exp.right_count) begin
          note_failure($sformatf({"mismatch exp st=%0d lf=%0d lc=%0d rf=%0d rc=%0d",
                                  " got st=%0d lf=%0d lc=%0d rf=%0d rc=%0d"},
                                 exp.status, exp.left_first_row, exp.left_count,
                                 exp.right_first_row, exp.right_count,
                                 out_data_o.status, out_data_o.left_first_row,
                                 out_data_o.left_count, out_data_o.right_first_row,
                                 out_data_o.right_count));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes of keys and rows, every action, the named corner cases
    push_item(ACT_CLEAR, 32'sd0, '0, '0);
    push_item(ACT_PROBE, 32'sd5, 31'd10, 31'd2);              // empty table
    push_item(ACT_LOAD, 32'sh80000000, 31'd1, 31'd1);
    push_item(ACT_LOAD, -32'sd5, 31'h7FFFFFFF, 31'h7FFFFFFF);
    push_item(ACT_LOAD, 32'sd0, 31'd0, 31'd0);                 // zero rows stored as given
    push_item(ACT_LOAD, 32'sd7, 31'd100, 31'd3);
    push_item(ACT_LOAD, 32'sd7, 31'd103, 31'd2);               // duplicate right key
    push_item(ACT_LOAD, 32'sh7FFFFFFF, 31'd500, 31'd9);
    push_item(ACT_PROBE, 32'sh80000000, 31'd1, 31'd1);
    push_item(ACT_PROBE, -32'sd6, 31'h7FFFFFFF, 31'd0);
    push_item(ACT_PROBE, -32'sd5, 31'd0, 31'h7FFFFFFF);
    push_item(ACT_PROBE, 32'sd3, 31'd20, 31'd4);
    push_item(ACT_PROBE, 32'sd7, 31'd30, 31'd5);
    push_item(ACT_PROBE, 32'sd7, 31'd35, 31'd1);               // same key matches again
    push_item(ACT_PROBE, 32'sd6, 31'd40, 31'd1);               // out of order, pointer stays
    push_item(ACT_PROBE, 32'sh7FFFFFFF, 31'd50, 31'd6);
    push_item(ACT_PROBE, 32'sh7FFFFFFF, 31'd56, 31'd2);
    push_item(ACT_UNUSED, $urandom, 31'h7FFFFFFF, 31'h7FFFFFFF);
    push_item(ACT_CLEAR, 32'sd0, 31'd1, 31'd1);
    push_item(ACT_LOAD, 32'sd10, 31'd1, 31'd4);
    push_item(ACT_PROBE, 32'sd20, 31'd1, 31'd1);               // pointer runs off the end
    push_item(ACT_LOAD, 32'sd30, 31'd5, 31'd7);                // still reachable afterwards
    push_item(ACT_PROBE, 32'sd30, 31'd2, 31'd3);
    wait_drain();

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) void'(add_join_round());
    wait_drain();

    run_random_phase(0, 0);
    run_random_phase(63, 0);
    run_random_phase(0, 63);
    run_random_phase(33, 33);

    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (join_answers_q.size() != 0) begin
      note_failure("predicted answer never arrived");
      void'(join_answers_q.pop_front());
    end

    if (fail_count == 0) begin
      $display("sort_merge_join_groups_core_tb OK");
    end else begin
      $display("sort_merge_join_groups_core_tb NOT OK");
    end
    $finish;
  end

endmodule
